### sv/ssag_pkg.sv
// Shared widths, register indexes and controller/datapath interface types.
package ssag_pkg;

  // Default grid dimension limit
  localparam int MAX_DIM_DEF = 64;

  // Field widths
  localparam int DIM_W   = 7;   // grid_rows / grid_cols
  localparam int START_W = 8;   // start_row / start_col, signed
  localparam int CELL_W  = 6;   // cell_row / cell_col
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd3;

  // Controller -> datapath
  typedef struct packed {
    logic restart;     // reload scan state from start cell
    logic load_start;  // take the pending start position
    logic step;        // advance one spiral step
    logic emit;        // write current cell to output register
  } ssag_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic exhausted;   // cells given >= grid total
    logic pending;     // start cell not yet taken
    logic in_grid;     // current position lies in the grid
    logic step_fail;   // spiral has outgrown its leg limit
    logic out_free;    // output register can take a beat
  } ssag_sts_t;

endpackage

### sv/ssag_ctrl.sv
// Sequencing state machine for the spiral scan.
module ssag_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                restart,
  input  ssag_pkg::ssag_sts_t sts,
  output ssag_pkg::ssag_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;
  localparam logic [1:0] S_TEST  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.restart = restart;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.exhausted) begin
          state_next = S_IDLE;
        end else if (sts.pending) begin
          cmd.load_start = 1'b1;
          state_next     = S_TEST;
        end else begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        // previous cell already given: move before testing
        if (sts.step_fail) begin
          state_next = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (sts.in_grid) begin
          if (sts.out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        end else if (sts.step_fail) begin
          state_next = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/ssag_dp.sv
// Spiral position, leg counters, config registers and output register.
module ssag_dp #(
  parameter int MAX_DIM = ssag_pkg::MAX_DIM_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  input  logic [ssag_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ssag_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  ssag_pkg::ssag_cmd_t                     cmd,
  output ssag_pkg::ssag_sts_t                     sts,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [ssag_pkg::CELL_W-1:0]             cell_row,
  output logic [ssag_pkg::CELL_W-1:0]             cell_col,
  output logic                                    last_cell
);

  localparam int DIM_W   = ssag_pkg::DIM_W;
  localparam int START_W = ssag_pkg::START_W;
  localparam int CELL_W  = ssag_pkg::CELL_W;
  localparam int DIM_MAXV = (1 << DIM_W) - 1;
  localparam int DIM_EFF  = (MAX_DIM < DIM_MAXV) ? MAX_DIM : DIM_MAXV;
  localparam int LEG_LIMIT = 2 * MAX_DIM + 260;
  localparam int LEG_W = $clog2(LEG_LIMIT + 1);
  // start reach plus the spiral's largest excursion, plus sign
  localparam int POS_W = $clog2(128 + LEG_LIMIT / 2 + 2) + 1;
  localparam int CNT_W = $clog2(DIM_EFF * DIM_EFF + 1);

  localparam logic [DIM_W-1:0] DIM_CAP   = DIM_W'(DIM_EFF);
  localparam logic [LEG_W-1:0] LEG_LIM_V = LEG_W'(LEG_LIMIT);

  // config registers
  logic [DIM_W-1:0]   grid_rows;
  logic [DIM_W-1:0]   grid_cols;
  logic [START_W-1:0] start_row;
  logic [START_W-1:0] start_col;

  // scan state
  logic [POS_W-1:0] pos_row;
  logic [POS_W-1:0] pos_col;
  logic [LEG_W-1:0] leg_length;
  logic             leg_phase;
  logic [LEG_W-1:0] steps_left;
  logic [CNT_W-1:0] cells_emitted;
  logic             start_pending;
  logic [CNT_W-1:0] total;

  logic [DIM_W-1:0]   rows_c;
  logic [DIM_W-1:0]   cols_c;
  logic [2*DIM_W-1:0] prod;
  logic [POS_W-1:0]   start_row_x;
  logic [POS_W-1:0]   start_col_x;
  logic [LEG_W-1:0]   leg_s;
  logic               phase_s;
  logic [LEG_W-1:0]   steps_s;
  logic [POS_W-1:0]   row_s;
  logic [POS_W-1:0]   col_s;
  logic [CNT_W-1:0]   cells_inc;

  assign rows_c = (grid_rows > DIM_CAP) ? DIM_CAP : grid_rows;
  assign cols_c = (grid_cols > DIM_CAP) ? DIM_CAP : grid_cols;
  assign prod   = (2*DIM_W)'(rows_c) * (2*DIM_W)'(cols_c);

  assign start_row_x = {{(POS_W-START_W){start_row[START_W-1]}}, start_row};
  assign start_col_x = {{(POS_W-START_W){start_col[START_W-1]}}, start_col};

  assign cells_inc = cells_emitted + CNT_W'(1);

  // one spiral step
  always_comb begin
    leg_s   = leg_length;
    phase_s = leg_phase;
    steps_s = steps_left;
    row_s   = pos_row;
    col_s   = pos_col;
    if (steps_left == '0) begin
      if (leg_phase || (leg_length == '0)) begin
        leg_s   = leg_length + LEG_W'(1);
        phase_s = 1'b0;
      end else begin
        phase_s = 1'b1;
      end
      steps_s = leg_s;
    end
    if (leg_s[0]) begin
      if (!phase_s) row_s = pos_row - POS_W'(1);
      else          col_s = pos_col - POS_W'(1);
    end else begin
      if (!phase_s) row_s = pos_row + POS_W'(1);
      else          col_s = pos_col + POS_W'(1);
    end
    steps_s = steps_s - LEG_W'(1);
  end

  always_comb begin
    sts.exhausted = (cells_emitted >= total);
    sts.pending   = start_pending;
    sts.in_grid   = !pos_row[POS_W-1] && !pos_col[POS_W-1] &&
                    (pos_row < {{(POS_W-DIM_W){1'b0}}, rows_c}) &&
                    (pos_col < {{(POS_W-DIM_W){1'b0}}, cols_c});
    sts.step_fail = (steps_left == '0) && (leg_phase || (leg_length == '0)) &&
                    (leg_length >= LEG_LIM_V);
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= DIM_W'(1);
      grid_cols <= DIM_W'(1);
      start_row <= '0;
      start_col <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssag_pkg::CFG_GRID_ROWS: grid_rows <= cfg_data[DIM_W-1:0];
        ssag_pkg::CFG_GRID_COLS: grid_cols <= cfg_data[DIM_W-1:0];
        ssag_pkg::CFG_START_ROW: start_row <= cfg_data[START_W-1:0];
        ssag_pkg::CFG_START_COL: start_col <= cfg_data[START_W-1:0];
        default: ;
      endcase
    end
  end

  // total is registered from config and follows it in the cycle after; read no earlier than the check state
  always_ff @(posedge clk) begin
    total <= prod[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_row       <= '0;
      pos_col       <= '0;
      leg_length    <= '0;
      leg_phase     <= 1'b0;
      steps_left    <= '0;
      cells_emitted <= '0;
      start_pending <= 1'b1;
    end else if (cmd.restart) begin
      pos_row       <= start_row_x;
      pos_col       <= start_col_x;
      leg_length    <= '0;
      leg_phase     <= 1'b0;
      steps_left    <= '0;
      cells_emitted <= '0;
      start_pending <= 1'b1;
    end else begin
      if (cmd.load_start) begin
        pos_row       <= start_row_x;
        pos_col       <= start_col_x;
        start_pending <= 1'b0;
      end
      if (cmd.step) begin
        pos_row    <= row_s;
        pos_col    <= col_s;
        leg_length <= leg_s;
        leg_phase  <= phase_s;
        steps_left <= steps_s;
      end
      if (cmd.emit) begin
        cells_emitted <= cells_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cell_row  <= pos_row[CELL_W-1:0];
      cell_col  <= pos_col[CELL_W-1:0];
      last_cell <= (cells_inc == total);
    end
  end

endmodule

### sv/spiral_scan_address_generator.sv
// Top level of the spiral scan address generator: controller plus datapath.
//
//  channel   dir   handshake               payload
//  -------   ---   ---------------------   ------------------------------
//  in        in    in_valid / in_ready     restart
//  out       out   out_valid / out_ready   cell_row, cell_col, last_cell
//  cfg       in    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Sequence: after accept a request beat passes through the check state, then
//   walks the spiral, one step per cycle through the position adders, testing
//   each position; a cell inside the grid is emitted once the output register is
//   free, and the next request is taken back in the idle state.
//   Exhausted scans return to idle with no result.
// Reset: rst (sync) gives a 1 x 1 grid, start (0, 0), scan at its beginning.
// Stalls: the output register holds one result; a new request is taken while
//   it waits, and the scan stalls only when its next cell finds it still full.
// Config beats are always taken (cfg_ready tied high).
module spiral_scan_address_generator #(
  parameter int MAX_DIM = ssag_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              restart,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ssag_pkg::CELL_W-1:0]       cell_row,
  output logic [ssag_pkg::CELL_W-1:0]       cell_col,
  output logic                              last_cell,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssag_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ssag_pkg::ssag_cmd_t cmd;
  ssag_pkg::ssag_sts_t sts;

  // config registers live in the datapath and take every beat
  assign cfg_ready = 1'b1;

  // sequencer: idle -> check -> (step) -> test loop -> emit
  ssag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .sts      (sts),
    .cmd      (cmd)
  );

  // position, leg counters, bounds test and output register
  ssag_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cell_row  (cell_row),
    .cell_col  (cell_col),
    .last_cell (last_cell)
  );

`ifndef SYNTH
  // a result is only written into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("emit into occupied output register");

  // an emitted cell is presented on the next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted beat not presented");

  // emit only on a cell inside the grid, never together with a step
  a_emit_in_grid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (sts.in_grid && !cmd.step && !cmd.load_start))
    else $error("emit on outside cell or with a step");

  // the block is busy for at least the check cycle after a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken during check");
`endif

endmodule
